[rtl/chunked_transfer_decoder_assert.svh]
// Assertion macros for the chunked transfer decoder.
// Both macros sample on i_clk and stand down while i_rst_n is low.
`ifndef CHUNKED_TRANSFER_DECODER_ASSERT_SVH
`define CHUNKED_TRANSFER_DECODER_ASSERT_SVH

`ifndef SYNTH

// Check a property on every clock edge.
`define CTD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("chunked_transfer_decoder: assertion failed");

// Check that a condition in one cycle implies another in the next cycle.
`define CTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) \
        else $error("chunked_transfer_decoder: assertion failed");

`else

`define CTD_ASSERT(label, prop)
`define CTD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/ctd_pkg.sv]
package ctd_pkg;

    // Default sizing of the decoder
    localparam int DEF_SIZE_BITS    = 32;
    localparam int DEF_LENGTH_BITS  = 32;
    localparam int DEF_MAX_TRAILERS = 8;
    localparam int DEF_MAX_NAME     = 64;
    localparam int DEF_MAX_VALUE    = 256;

    // One hex digit per size byte (base 16)
    localparam int DIGIT_BITS = 4;

    // Characters of the chunked syntax
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_OK      = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

endpackage

[rtl/chunked_transfer_decoder.sv]
// Channel   Direction  Handshake            Word
// -------   ---------  -------------------  -------------------------------------------
// input     in         i_valid / o_stall    i_in_byte, i_end_of_input
// result    out        o_valid / i_stall    o_kind, o_payload_byte, o_payload_length,
//                                           o_bytes_consumed, o_trailer_count
//
// One word per cycle while o_stall is low: each input word is decoded in the cycle it is
// accepted and its result, if any, lands in the output register at that edge.
// The parser state and counters update in a single pass of narrow logic; the widest
// path is the SIZE_BITS chunk counter decrement and the LENGTH_BITS saturating adds.
// o_stall rises only while a result is held in the output register and i_stall is high.
// Reset (i_rst_n low, synchronous) returns the parser to the start of a size line and
// empties the output register; an end-of-input word does the same to the parser.
module chunked_transfer_decoder #(
    parameter int SIZE_BITS    = ctd_pkg::DEF_SIZE_BITS,
    parameter int LENGTH_BITS  = ctd_pkg::DEF_LENGTH_BITS,
    parameter int MAX_TRAILERS = ctd_pkg::DEF_MAX_TRAILERS,
    parameter int MAX_NAME     = ctd_pkg::DEF_MAX_NAME,
    parameter int MAX_VALUE    = ctd_pkg::DEF_MAX_VALUE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_input,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [31:0] o_payload_length,
    output logic [31:0] o_bytes_consumed,
    output logic [3:0]  o_trailer_count
);
    import ctd_pkg::*;

    localparam int NW  = $clog2(MAX_NAME + 1);
    localparam int VW  = $clog2(MAX_VALUE + 1);
    localparam int TW  = $clog2(MAX_TRAILERS + 1);
    localparam int LW  = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;
    localparam int TLW = (TW > 4) ? TW : 4;

    typedef enum logic [3:0] {
        PH_SIZE0,
        PH_SIZE,
        PH_SIZE_CR,
        PH_EXT,
        PH_EXT_CR,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_TR_START,
        PH_TR_LINE,
        PH_TR_CR,
        PH_TR_END_CR,
        PH_DONE
    } t_phase;

    // Per-line trailer bookkeeping
    typedef struct packed {
        logic          colon;
        logic [NW-1:0] name_len;
        logic [VW-1:0] value_len;
    } t_line;

    typedef struct packed {
        logic                  ok;
        logic [DIGIT_BITS-1:0] val;
    } t_hex;

    localparam t_line LINE_CLEAR = '{colon: 1'b0, name_len: '0, value_len: '0};

    function automatic t_hex hex_decode(input logic [7:0] b);
        t_hex h;
        h.ok  = 1'b1;
        h.val = '0;
        if (b >= "0" && b <= "9") begin
            h.val = DIGIT_BITS'(b - "0");
        end else if (b >= "a" && b <= "f") begin
            h.val = DIGIT_BITS'(b - "a" + 8'd10);
        end else if (b >= "A" && b <= "F") begin
            h.val = DIGIT_BITS'(b - "A" + 8'd10);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    // Count one content byte of a trailer line
    function automatic t_line line_content(input t_line l, input logic [7:0] b);
        t_line r;
        r = l;
        if (!l.colon) begin
            if (b == CH_COLON) begin
                r.colon = 1'b1;
            end else if (l.name_len < NW'(MAX_NAME)) begin
                r.name_len = l.name_len + 1'b1;
            end
        end else if (!(l.value_len == '0 && b == CH_SPACE)) begin
            if (l.value_len < VW'(MAX_VALUE)) begin
                r.value_len = l.value_len + 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
        return (v != '1) ? v + 1'b1 : v;
    endfunction

    function automatic logic [31:0] clip32(input logic [LENGTH_BITS-1:0] v);
        logic [LW-1:0] w;
        w = LW'(v);
        return (w > LW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    function automatic logic [3:0] clip4(input logic [TW-1:0] v);
        logic [TLW-1:0] w;
        w = TLW'(v);
        return (w > TLW'(4'hF)) ? 4'hF : w[3:0];
    endfunction

    // Parser state
    t_phase                 r_phase,    n_phase;
    logic [SIZE_BITS-1:0]   r_chunk,    n_chunk;
    logic [SIZE_BITS-1:0]   r_accum,    n_accum;
    logic [LENGTH_BITS-1:0] r_payload,  n_payload;
    logic [LENGTH_BITS-1:0] r_consumed, n_consumed;
    logic [TW-1:0]          r_trailers, n_trailers;
    t_line                  r_line,     n_line;
    logic                   r_error,    n_error;

    // Output register
    logic        r_valid;
    t_kind       r_kind;
    logic [7:0]  r_byte;
    logic [31:0] r_plen;
    logic [31:0] r_bcons;
    logic [3:0]  r_tcount;

    logic  w_accept;
    logic  w_emit_byte;
    logic  w_emit_end;
    t_hex  w_hex;
    t_line w_cr_line;

    // Hold the input only while a result waits and the sink stalls
    assign o_stall  = r_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;
    assign w_hex    = hex_decode(i_in_byte);
    // A CR that turned out not to start CRLF counts as line content
    assign w_cr_line = line_content(r_line, CH_CR);

    always_comb begin
        n_phase     = r_phase;
        n_chunk     = r_chunk;
        n_accum     = r_accum;
        n_payload   = r_payload;
        n_consumed  = r_consumed;
        n_trailers  = r_trailers;
        n_line      = r_line;
        n_error     = r_error;
        w_emit_byte = 1'b0;
        w_emit_end  = 1'b0;

        if (i_end_of_input) begin
            // Report status, then drop everything back to the start state
            w_emit_end = 1'b1;
            n_phase    = PH_SIZE0;
            n_chunk    = '0;
            n_accum    = '0;
            n_payload  = '0;
            n_consumed = '0;
            n_trailers = '0;
            n_line     = LINE_CLEAR;
            n_error    = 1'b0;
        end else if (r_phase != PH_DONE) begin
            n_consumed = sat_inc(r_consumed);
            if (!r_error) begin
                case (r_phase)
                    PH_SIZE0, PH_SIZE: begin
                        if (w_hex.ok) begin
                            if (r_accum[SIZE_BITS-1 -: DIGIT_BITS] != '0) begin
                                n_error = 1'b1;
                            end else begin
                                n_accum = {r_accum[SIZE_BITS-DIGIT_BITS-1:0], w_hex.val};
                                n_phase = PH_SIZE;
                            end
                        end else if (r_phase == PH_SIZE && i_in_byte == CH_SEMI) begin
                            n_phase = PH_EXT;
                        end else if (r_phase == PH_SIZE && i_in_byte == CH_CR) begin
                            n_phase = PH_SIZE_CR;
                        end else begin
                            n_error = 1'b1;
                        end
                    end
                    PH_SIZE_CR, PH_EXT_CR: begin
                        if (i_in_byte == CH_LF) begin
                            n_accum = '0;
                            if (r_accum == '0) begin
                                n_phase = PH_TR_START;
                            end else begin
                                n_chunk = r_accum;
                                n_phase = PH_DATA;
                            end
                        end else if (r_phase == PH_SIZE_CR) begin
                            n_error = 1'b1;
                        end else if (i_in_byte != CH_CR) begin
                            n_phase = PH_EXT;
                        end
                    end
                    PH_EXT: begin
                        if (i_in_byte == CH_CR) begin
                            n_phase = PH_EXT_CR;
                        end
                    end
                    PH_DATA: begin
                        n_chunk     = r_chunk - 1'b1;
                        n_payload   = sat_inc(r_payload);
                        w_emit_byte = 1'b1;
                        if (r_chunk == SIZE_BITS'(1)) begin
                            n_phase = PH_DATA_CR;
                        end
                    end
                    PH_DATA_CR: begin
                        if (i_in_byte == CH_CR) begin
                            n_phase = PH_DATA_LF;
                        end else begin
                            n_error = 1'b1;
                        end
                    end
                    PH_DATA_LF: begin
                        if (i_in_byte == CH_LF) begin
                            n_phase = PH_SIZE0;
                        end else begin
                            n_error = 1'b1;
                        end
                    end
                    PH_TR_START: begin
                        if (i_in_byte == CH_CR) begin
                            n_line  = LINE_CLEAR;
                            n_phase = PH_TR_END_CR;
                        end else begin
                            n_line  = line_content(LINE_CLEAR, i_in_byte);
                            n_phase = PH_TR_LINE;
                        end
                    end
                    PH_TR_LINE: begin
                        if (i_in_byte == CH_CR) begin
                            n_phase = PH_TR_CR;
                        end else begin
                            n_line = line_content(r_line, i_in_byte);
                        end
                    end
                    PH_TR_CR, PH_TR_END_CR: begin
                        if (i_in_byte == CH_LF) begin
                            if (r_phase == PH_TR_END_CR) begin
                                n_phase = PH_DONE;
                            end else begin
                                if (r_line.colon && r_trailers < TW'(MAX_TRAILERS) &&
                                    r_line.name_len < NW'(MAX_NAME) &&
                                    r_line.value_len < VW'(MAX_VALUE)) begin
                                    n_trailers = r_trailers + 1'b1;
                                end
                                n_line  = LINE_CLEAR;
                                n_phase = PH_TR_START;
                            end
                        end else if (i_in_byte == CH_CR) begin
                            n_line  = w_cr_line;
                            n_phase = PH_TR_CR;
                        end else begin
                            n_line  = line_content(w_cr_line, i_in_byte);
                            n_phase = PH_TR_LINE;
                        end
                    end
                    default: begin
                        n_error = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SIZE0;
            r_chunk    <= '0;
            r_accum    <= '0;
            r_payload  <= '0;
            r_consumed <= '0;
            r_trailers <= '0;
            r_line     <= LINE_CLEAR;
            r_error    <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase    <= n_phase;
                r_chunk    <= n_chunk;
                r_accum    <= n_accum;
                r_payload  <= n_payload;
                r_consumed <= n_consumed;
                r_trailers <= n_trailers;
                r_line     <= n_line;
                r_error    <= n_error;
            end
            // Load a new result, or drain the held one once the sink takes it
            if (w_accept && (w_emit_byte || w_emit_end)) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload; no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit_byte) begin
            r_kind   <= KIND_PAYLOAD;
            r_byte   <= i_in_byte;
            r_plen   <= '0;
            r_bcons  <= '0;
            r_tcount <= '0;
        end else if (w_accept && w_emit_end) begin
            r_kind   <= (!r_error && r_phase == PH_DONE) ? KIND_OK : KIND_ERROR;
            r_byte   <= '0;
            r_plen   <= clip32(r_payload);
            r_bcons  <= clip32(r_consumed);
            r_tcount <= clip4(r_trailers);
        end
    end

    assign o_valid          = r_valid;
    assign o_kind           = r_kind;
    assign o_payload_byte   = r_byte;
    assign o_payload_length = r_plen;
    assign o_bytes_consumed = r_bcons;
    assign o_trailer_count  = r_tcount;

`include "chunked_transfer_decoder_assert.svh"

    `CTD_ASSERT(a_payload_fields_zero, r_valid && r_kind == KIND_PAYLOAD |-> r_plen == '0 && r_bcons == '0 && r_tcount == '0)
    `CTD_ASSERT_NEXT(a_end_restarts, w_accept && i_end_of_input, r_phase == PH_SIZE0 && !r_error && r_consumed == '0 && r_payload == '0)
    `CTD_ASSERT_NEXT(a_no_payload_after_error, w_accept && !i_end_of_input && r_error, !r_valid)
    `CTD_ASSERT(a_trailer_limit, r_trailers <= TW'(MAX_TRAILERS))

endmodule

[verif/chunked_transfer_decoder_tb.sv]
module chunked_transfer_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ctd_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_PERCENT  = 12;
    localparam int TARGET_WORDS  = 1400;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;
    // Worst case is a few thousand words, each waiting out a stall and a gap,
    // plus the long receiver hold; take it many times over.
    localparam int CYCLE_LIMIT   = 200000;

    // Parser phases of the decoder, tracked by the predictor below.
    typedef enum logic [3:0] {
        PH_SIZE_START,
        PH_SIZE_DIGITS,
        PH_SIZE_LF,
        PH_EXT_TEXT,
        PH_EXT_LF,
        PH_CHUNK_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_TRAILER_START,
        PH_TRAILER_TEXT,
        PH_TRAILER_LF,
        PH_END_LF,
        PH_COMPLETE
    } t_parse_phase;

    typedef struct {
        t_kind       kind;
        logic [7:0]  data;
        logic [31:0] length;
        logic [31:0] consumed;
        logic [3:0]  trailers;
    } t_decoder_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_in_byte;
    logic        i_end_of_input;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [7:0]  o_payload_byte;
    logic [31:0] o_payload_length;
    logic [31:0] o_bytes_consumed;
    logic [3:0]  o_trailer_count;

    chunked_transfer_decoder i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_in_byte        (i_in_byte),
        .i_end_of_input   (i_end_of_input),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_payload_byte   (o_payload_byte),
        .o_payload_length (o_payload_length),
        .o_bytes_consumed (o_bytes_consumed),
        .o_trailer_count  (o_trailer_count)
    );

    // Predictor state: a private copy of the parser.
    t_parse_phase dec_phase;
    logic [31:0]  dec_chunk_left;
    logic [31:0]  dec_size;
    logic [31:0]  dec_payload;
    logic [31:0]  dec_consumed;
    logic [3:0]   dec_trailers;
    logic         dec_colon;
    logic [6:0]   dec_name_len;
    logic [8:0]   dec_value_len;
    logic         dec_error;

    // Results that the decoder still owes, oldest first.
    t_decoder_result awaited_results[$];

    // Body of the message under construction.
    logic [7:0] msg[$];

    bit idle_enable;
    int stall_hold;
    int cycle_count;
    int mismatch_count;
    int words_sent;
    int messages_sent;
    int ok_seen;
    int err_seen;
    int payload_seen;
    t_decoder_result head;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic int hex_value(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return -1;
    endfunction

    function automatic void clear_line();
        dec_colon     = 1'b0;
        dec_name_len  = '0;
        dec_value_len = '0;
    endfunction

    function automatic void reset_parser();
        dec_phase      = PH_SIZE_START;
        dec_chunk_left = '0;
        dec_size       = '0;
        dec_payload    = '0;
        dec_consumed   = '0;
        dec_trailers   = '0;
        dec_error      = 1'b0;
        clear_line();
    endfunction

    // Count one byte of trailer text toward the name or the value.
    function automatic void count_line_byte(input logic [7:0] b);
        if (!dec_colon) begin
            if (b == CH_COLON) dec_colon = 1'b1;
            else if (dec_name_len < DEF_MAX_NAME) dec_name_len++;
        end else if (!(dec_value_len == 0 && b == CH_SPACE)) begin
            // leading spaces of the value are skipped
            if (dec_value_len < DEF_MAX_VALUE) dec_value_len++;
        end
    endfunction

    function automatic void take_trailer_byte(input logic [7:0] b);
        if (b == CH_CR) begin
            dec_phase = PH_TRAILER_LF;
        end else begin
            count_line_byte(b);
            dec_phase = PH_TRAILER_TEXT;
        end
    endfunction

    function automatic void close_size_line();
        if (dec_size == 0) begin
            dec_phase = PH_TRAILER_START;
        end else begin
            dec_chunk_left = dec_size;
            dec_phase      = PH_CHUNK_DATA;
        end
        dec_size = '0;
    endfunction

    // Advance the parser by one accepted word and queue any result it causes.
    function automatic void predict_decode(input logic [7:0] b, input logic eoi);
        t_decoder_result r;
        int d;
        if (eoi) begin
            r.kind     = (!dec_error && dec_phase == PH_COMPLETE) ? KIND_OK : KIND_ERROR;
            r.data     = '0;
            r.length   = dec_payload;
            r.consumed = dec_consumed;
            r.trailers = dec_trailers;
            awaited_results.push_back(r);
            reset_parser();
            return;
        end
        // after the terminator bytes are dropped uncounted
        if (dec_phase == PH_COMPLETE) return;
        dec_consumed = bump(dec_consumed);
        if (dec_error) return;

        case (dec_phase)
            PH_SIZE_START, PH_SIZE_DIGITS: begin
                d = hex_value(b);
                if (d >= 0) begin
                    if (dec_size[31:28] != 0) begin
                        dec_error = 1'b1;
                    end else begin
                        dec_size  = {dec_size[27:0], d[3:0]};
                        dec_phase = PH_SIZE_DIGITS;
                    end
                end else if (dec_phase == PH_SIZE_DIGITS && b == CH_SEMI) begin
                    dec_phase = PH_EXT_TEXT;
                end else if (dec_phase == PH_SIZE_DIGITS && b == CH_CR) begin
                    dec_phase = PH_SIZE_LF;
                end else begin
                    dec_error = 1'b1;
                end
            end
            PH_SIZE_LF: begin
                if (b == CH_LF) close_size_line();
                else dec_error = 1'b1;
            end
            PH_EXT_TEXT: begin
                if (b == CH_CR) dec_phase = PH_EXT_LF;
            end
            PH_EXT_LF: begin
                if (b == CH_LF) close_size_line();
                else if (b != CH_CR) dec_phase = PH_EXT_TEXT;
            end
            PH_CHUNK_DATA: begin
                dec_chunk_left--;
                if (dec_chunk_left == 0) dec_phase = PH_DATA_CR;
                dec_payload = bump(dec_payload);
                r.kind     = KIND_PAYLOAD;
                r.data     = b;
                r.length   = '0;
                r.consumed = '0;
                r.trailers = '0;
                awaited_results.push_back(r);
            end
            PH_DATA_CR: begin
                if (b == CH_CR) dec_phase = PH_DATA_LF;
                else dec_error = 1'b1;
            end
            PH_DATA_LF: begin
                if (b == CH_LF) dec_phase = PH_SIZE_START;
                else dec_error = 1'b1;
            end
            PH_TRAILER_START: begin
                clear_line();
                if (b == CH_CR) dec_phase = PH_END_LF;
                else take_trailer_byte(b);
            end
            PH_END_LF: begin
                if (b == CH_LF) begin
                    dec_phase = PH_COMPLETE;
                end else begin
                    // lone CR at line start is plain text
                    count_line_byte(CH_CR);
                    take_trailer_byte(b);
                end
            end
            PH_TRAILER_TEXT: take_trailer_byte(b);
            PH_TRAILER_LF: begin
                if (b == CH_LF) begin
                    if (dec_colon && dec_trailers < DEF_MAX_TRAILERS &&
                        dec_name_len < DEF_MAX_NAME && dec_value_len < DEF_MAX_VALUE)
                        dec_trailers++;
                    clear_line();
                    dec_phase = PH_TRAILER_START;
                end else begin
                    count_line_byte(CH_CR);
                    take_trailer_byte(b);
                end
            end
            default: dec_error = 1'b1;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, receiver and checker
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Receiver: honor a requested hold first, else stall at random when idling is on.
    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            i_stall = 1'b1;
            stall_hold--;
        end else if (idle_enable) begin
            i_stall = ($urandom_range(99) < IDLE_PERCENT);
        end else begin
            i_stall = 1'b0;
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result kind %0d byte %02h len %0d cons %0d tr %0d",
                             $realtime, o_kind, o_payload_byte, o_payload_length,
                             o_bytes_consumed, o_trailer_count);
            end else begin
                head = awaited_results.pop_front();
                if (o_kind !== head.kind || o_payload_byte !== head.data ||
                    o_payload_length !== head.length || o_bytes_consumed !== head.consumed ||
                    o_trailer_count !== head.trailers) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: mismatch, expected kind %0d byte %02h len %0d",
                                 $realtime, head.kind, head.data, head.length);
                        $display("%0t:           expected cons %0d tr %0d",
                                 $realtime, head.consumed, head.trailers);
                        $display("%0t:           got kind %0d byte %02h len %0d",
                                 $realtime, o_kind, o_payload_byte, o_payload_length);
                        $display("%0t:           got cons %0d tr %0d",
                                 $realtime, o_bytes_consumed, o_trailer_count);
                    end
                end
            end
            case (o_kind)
                KIND_OK:      ok_seen++;
                KIND_ERROR:   err_seen++;
                default:      payload_seen++;
            endcase
        end
    end

    // Stop a hung run.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, awaited_results.size());
        $display("chunked_transfer_decoder regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one word; enter and leave at a falling edge, hold the word until taken.
    task automatic send_word(input logic [7:0] b, input logic eoi);
        if (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_in_byte      = b;
        i_end_of_input = eoi;
        do @(posedge i_clk); while (o_stall);
        predict_decode(b, eoi);
        words_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Send the built body, close it with an end word and clear the buffer.
    task automatic send_message();
        foreach (msg[i]) send_word(msg[i], 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'b1);
        messages_sent++;
        msg.delete();
    endtask

    // Hold the input idle until every owed result has come out.
    task automatic wait_drained();
        i_valid = 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Message building
    // ------------------------------------------------------------------

    function automatic void put_byte(input logic [7:0] b);
        msg.push_back(b);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
    endfunction

    function automatic void put_crlf();
        msg.push_back(CH_CR);
        msg.push_back(CH_LF);
    endfunction

    function automatic void put_line(input string s);
        put_text(s);
        put_crlf();
    endfunction

    function automatic void put_repeat(input logic [7:0] b, input int n);
        repeat (n) msg.push_back(b);
    endfunction

    // Hex size with optional leading zeros and mixed letter case.
    function automatic void put_hex(input logic [31:0] v, input int zeros);
        int top;
        logic [3:0] nib;
        top = 7;
        while (top > 0 && v[top*4 +: 4] == 0) top--;
        repeat (zeros) msg.push_back("0");
        for (int i = top; i >= 0; i--) begin
            nib = v[i*4 +: 4];
            if (nib < 10) msg.push_back("0" + nib);
            else msg.push_back(8'((($urandom_range(1) != 0) ? "a" : "A") + nib - 10));
        end
    endfunction

    function automatic logic [7:0] line_char(input bit allow_colon);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == CH_CR || (!allow_colon && c == CH_COLON));
        return c;
    endfunction

    // Noise leans on the bytes the syntax cares about.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(5))
            0:       return CH_CR;
            1:       return CH_LF;
            2:       return CH_SEMI;
            3:       return CH_COLON;
            4:       return 8'("0" + $urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void put_extension();
        put_byte(CH_SEMI);
        repeat ($urandom_range(0, 6)) put_byte(line_char(1'b1));
        if ($urandom_range(3) == 0) begin
            // lone CR, sometimes doubled before the real CRLF
            put_byte(CH_CR);
            if ($urandom_range(1) == 0) put_byte(line_char(1'b1));
        end
    endfunction

    function automatic void put_trailer();
        int name_len;
        int value_len;
        name_len  = ($urandom_range(24) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 6);
        value_len = ($urandom_range(24) == 0) ? $urandom_range(250, 260) : $urandom_range(0, 8);
        repeat (name_len) put_byte(line_char(1'b0));
        if ($urandom_range(9) != 0) put_byte(CH_COLON);
        repeat ($urandom_range(0, 2)) put_byte(CH_SPACE);
        repeat (value_len) put_byte(line_char(1'b1));
        if ($urandom_range(9) == 0) begin
            put_byte(CH_CR);
            put_byte(line_char(1'b1));
        end
        put_crlf();
    endfunction

    // Well-formed body with random content; a few are broken afterwards.
    function automatic void build_random_message();
        int size;
        int pick;
        int cut;
        repeat ($urandom_range(0, 3)) begin
            size = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            put_hex(size, $urandom_range(0, 2));
            if ($urandom_range(3) == 0) put_extension();
            put_crlf();
            repeat (size) put_byte(8'($urandom_range(0, 255)));
            put_crlf();
        end
        put_hex(0, $urandom_range(0, 2));
        if ($urandom_range(3) == 0) put_extension();
        put_crlf();
        repeat (($urandom_range(9) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 3))
            put_trailer();
        put_crlf();
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));

        pick = $urandom_range(99);
        if (pick < 6) begin
            msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (pick < 12) begin
            cut = $urandom_range(0, msg.size() - 1);
            while (msg.size() > cut) void'(msg.pop_back());
        end else if (pick < 15) begin
            msg.delete();
            repeat ($urandom_range(0, 16)) put_byte(noise_byte());
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_well_formed();
        put_line("3");
        put_line("abc");
        put_line("0");
        put_crlf();
        send_message();

        // Uppercase size, extension with lone CRs, extreme payload bytes,
        // padded zero size and junk after the terminator.
        put_text("A;x=1");
        put_byte(CH_CR);
        put_text("z");
        put_byte(CH_CR);
        put_crlf();
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h55);
        put_byte(8'hAA);
        put_text("0123AB");
        put_crlf();
        put_line("0000");
        put_crlf();
        put_text("xyz");
        send_message();
    endtask

    task automatic test_size_line_errors();
        put_line("g");               // non-hex digit
        send_message();
        put_crlf();                  // empty size field
        send_message();
        put_line(";ext");            // extension with no size
        send_message();
        put_line("100000000");       // does not fit in 32 bits
        send_message();
        put_text("1");               // CR not followed by LF
        put_byte(CH_CR);
        put_line("x");
        send_message();
        put_line("FFFFFFFF");        // largest size, cut short
        put_text("abcd");
        send_message();
    endtask

    task automatic test_chunk_end_errors();
        put_line("1");
        put_text("xY");              // missing CR after data
        send_message();
        // Missing LF, then a well-formed tail that the sticky error must swallow.
        put_line("2");
        put_text("xy");
        put_byte(CH_CR);
        put_text("Z");
        put_line("1");
        put_line("a");
        put_line("0");
        put_crlf();
        send_message();
    endtask

    task automatic test_truncation();
        send_message();              // empty message
        put_line("0");               // trailer never closed
        put_text("k:v");
        send_message();
        put_line("0");
        send_message();
    endtask

    task automatic test_trailer_limits();
        put_line("1");
        put_line("q");
        put_line("0");
        put_repeat("n", DEF_MAX_NAME - 1);   // longest counted name
        put_text(":");
        put_repeat("v", DEF_MAX_VALUE - 1);  // longest counted value
        put_crlf();
        put_repeat("n", DEF_MAX_NAME);       // name too long
        put_line(":v");
        put_text("n:");
        put_repeat("v", DEF_MAX_VALUE);      // value too long
        put_crlf();
        put_line("n:    v");                 // leading spaces skipped
        put_line("nocolon");
        put_text("a:b");                     // lone CR inside a line
        put_byte(CH_CR);
        put_line("c");
        put_byte(CH_CR);                     // lone CR at line start
        put_line("X:y");
        repeat (DEF_MAX_TRAILERS) put_line("k:v");   // run past the trailer cap
        put_crlf();
        send_message();
    endtask

    // Run several messages with no idling on either side.
    task automatic test_full_rate();
        idle_enable = 1'b0;
        repeat (4) begin
            build_random_message();
            send_message();
        end
        idle_enable = 1'b1;
    endtask

    // Hold the receiver off long enough that the output fills and the input stalls.
    task automatic test_back_pressure();
        @(posedge i_clk);
        stall_hold = 150;
        @(negedge i_clk);
        put_line("28");
        repeat (40) put_byte(8'($urandom_range(0, 255)));
        put_crlf();
        put_line("0");
        put_crlf();
        send_message();
    endtask

    // Pause the sender until the decoder has returned everything.
    task automatic test_sender_pause();
        build_random_message();
        send_message();
        wait_drained();
        build_random_message();
        send_message();
    endtask

    // Top the run up with random messages until the word budget is spent.
    task automatic test_random_messages();
        while (words_sent < TARGET_WORDS) begin
            build_random_message();
            send_message();
            if ($urandom_range(7) == 0) wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_in_byte      = '0;
        i_end_of_input = 1'b0;
        i_stall        = 1'b0;
        idle_enable    = 1'b1;
        stall_hold     = 0;
        cycle_count    = 0;
        mismatch_count = 0;
        words_sent     = 0;
        messages_sent  = 0;
        ok_seen        = 0;
        err_seen       = 0;
        payload_seen   = 0;
        reset_parser();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_well_formed();
        test_size_line_errors();
        test_chunk_end_errors();
        test_truncation();
        test_trailer_limits();
        test_full_rate();
        test_back_pressure();
        test_sender_pause();
        test_random_messages();

        // Drain, then give the output register room to show any stray result.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("ran %0d messages over %0d input words in %0d cycles",
                 messages_sent, words_sent, cycle_count);
        $display("checked %0d payload bytes, %0d ok endings, %0d error endings",
                 payload_seen, ok_seen, err_seen);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("chunked_transfer_decoder regression: pass");
        end else begin
            $display("%0d mismatches, %0d results missing",
                     mismatch_count, awaited_results.size());
            $display("chunked_transfer_decoder regression: fail");
        end
        $finish;
    end

endmodule
